// ===== src/base64_scrambled_codec_core_macros.svh =====
// Assertion shorthands shared by the codec RTL.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef BASE64_SCRAMBLED_CODEC_CORE_MACROS_SVH
`define BASE64_SCRAMBLED_CODEC_CORE_MACROS_SVH

// Same-cycle implication.
`define B64SC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B64SC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/b64sc_pkg.sv =====
package b64sc_pkg;

  localparam int BATCH_MAX  = 4;
  localparam int BATCH_CW   = $clog2(BATCH_MAX + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION   = 3'd0,
    REG_UPPER_SHIFT = 3'd1,
    REG_LOWER_SHIFT = 3'd2,
    REG_DIGIT_SHIFT = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       carries_data;
    logic       last_of_message;
  } result_t;

  typedef struct packed {
    logic       direction;
    logic [4:0] upper_shift;
    logic [4:0] lower_shift;
    logic [3:0] digit_shift;
  } cfg_t;

  typedef struct packed {
    logic [11:0] bit_buffer;
    logic [3:0]  bits_held;
    logic [1:0]  chars_mod_four;
    logic        decode_halted;
  } state_t;

  // All words that one input item produces, word 0 goes out first.
  typedef struct packed {
    logic [BATCH_CW-1:0]          count;
    result_t [BATCH_MAX-1:0]      words;
  } batch_t;

  localparam cfg_t CFG_RESET = '{direction: 1'b0, upper_shift: 5'd3,
                                 lower_shift: 5'd5, digit_shift: 4'd7};

endpackage

// ===== src/b64sc_in_if.sv =====
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink   (input valid, input in_byte, input has_byte, input end_of_message,
                  output ready);
endinterface

// ===== src/b64sc_out_if.sv =====
interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       carries_data;
  logic       last_of_message;

  modport source (output valid, output out_byte, output carries_data,
                  output last_of_message, input ready);
  modport sink   (input valid, input out_byte, input carries_data,
                  input last_of_message, output ready);
endinterface

// ===== src/b64sc_cfg_if.sv =====
interface b64sc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [4:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/b64sc_step.sv =====
module b64sc_step
  import b64sc_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t st,
  input  item_t  item,
  output state_t st_nxt,
  output batch_t batch
);

  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_PAD    = 8'h3D;

  // Symbol to scrambled character; shifts arrive already reduced.
  function automatic logic [7:0] scramble(input logic [5:0] v, input logic [4:0] u,
                                          input logic [4:0] l, input logic [3:0] d);
    logic [5:0] t;
    logic [7:0] ch;
    t  = '0;
    ch = CH_USCORE;
    if (v < 6'd26) begin
      t = v + {1'b0, u};
      if (t >= 6'd26) t = t - 6'd26;
      ch = CH_UP_A + {2'b00, t};
    end else if (v < 6'd52) begin
      t = v - 6'd26 + {1'b0, l};
      if (t >= 6'd26) t = t - 6'd26;
      ch = CH_LO_A + {2'b00, t};
    end else if (v < 6'd62) begin
      t = v - 6'd52 + {2'b00, d};
      if (t >= 6'd10) t = t - 6'd10;
      ch = CH_ZERO + {2'b00, t};
    end else if (v == 6'd62) begin
      ch = CH_DASH;
    end
    return ch;
  endfunction

  // Scrambled character to symbol; bit 6 set flags a character outside the alphabet.
  function automatic logic [6:0] unscramble(input logic [7:0] c, input logic [4:0] u,
                                            input logic [4:0] l, input logic [3:0] d);
    logic [5:0] t;
    logic [6:0] v;
    t = '0;
    v = 7'd64;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = 6'(c - CH_UP_A) + (6'd26 - {1'b0, u});
      if (t >= 6'd26) t = t - 6'd26;
      v = {1'b0, t};
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = 6'(c - CH_LO_A) + (6'd26 - {1'b0, l});
      if (t >= 6'd26) t = t - 6'd26;
      v = 7'd26 + {1'b0, t};
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      t = 6'(c - CH_ZERO) + (6'd10 - {2'b00, d});
      if (t >= 6'd10) t = t - 6'd10;
      v = 7'd52 + {1'b0, t};
    end else if (c == CH_DASH || c == CH_PLUS) begin
      v = 7'd62;
    end else if (c == CH_USCORE || c == CH_SLASH) begin
      v = 7'd63;
    end
    return v;
  endfunction

  logic [4:0]          u_red, l_red;
  logic [3:0]          d_red;
  logic [11:0]         enc_buf;
  logic [4:0]          enc_bits, enc_rem;
  logic [1:0]          nsym, n_data, cmf_after, pads;
  logic                flush;
  logic [5:0]          sym0, sym1, fsym;
  logic [7:0]          ch0, ch1, chf;
  logic [2:0]          enc_total;
  logic [6:0]          dv;
  logic                dgo;
  logic [11:0]         dec_buf;
  logic [4:0]          dec_bits;
  logic [BATCH_CW-1:0] cnt;
  result_t [BATCH_MAX-1:0] w;
  state_t              ns;

  always_comb begin
    u_red = (cfg.upper_shift >= 5'd26) ? cfg.upper_shift - 5'd26 : cfg.upper_shift;
    l_red = (cfg.lower_shift >= 5'd26) ? cfg.lower_shift - 5'd26 : cfg.lower_shift;
    d_red = (cfg.digit_shift >= 4'd10) ? cfg.digit_shift - 4'd10 : cfg.digit_shift;

    // Encode: append the byte, cut off whole symbols from the top.
    enc_buf  = item.has_byte ? {st.bit_buffer[3:0], item.in_byte} : st.bit_buffer;
    enc_bits = item.has_byte ? {1'b0, st.bits_held} + 5'd8 : {1'b0, st.bits_held};
    if (!item.has_byte)        nsym = 2'd0;
    else if (enc_bits >= 5'd12) nsym = 2'd2;
    else if (enc_bits >= 5'd6)  nsym = 2'd1;
    else                        nsym = 2'd0;
    sym0    = 6'(enc_buf >> (enc_bits - 5'd6));
    sym1    = 6'(enc_buf >> (enc_bits - 5'd12));
    enc_rem = enc_bits - 5'd6 * {3'b000, nsym};
    flush   = item.end_of_message && enc_rem != 5'd0 && enc_rem < 5'd6;
    fsym    = 6'({enc_buf, 6'b000000} >> enc_rem);
    ch0     = scramble(sym0, u_red, l_red, d_red);
    ch1     = scramble(sym1, u_red, l_red, d_red);
    chf     = scramble(fsym, u_red, l_red, d_red);
    n_data    = nsym + {1'b0, flush};
    cmf_after = st.chars_mod_four + n_data;
    pads      = item.end_of_message ? 2'd0 - cmf_after : 2'd0;
    enc_total = {1'b0, n_data} + {1'b0, pads};
    if (enc_total > 3'(BATCH_MAX)) enc_total = 3'(BATCH_MAX);

    // Decode: one symbol in, at most one byte out.
    dv       = unscramble(item.in_byte, u_red, l_red, d_red);
    dgo      = item.has_byte && !st.decode_halted;
    dec_buf  = {st.bit_buffer[5:0], dv[5:0]};
    dec_bits = {1'b0, st.bits_held} + 5'd6;

    ns  = st;
    cnt = '0;
    w   = '0;
    if (!cfg.direction) begin
      for (int i = 0; i < BATCH_MAX; i++) begin
        if (3'(i) < enc_total) begin
          w[i].carries_data = 1'b1;
          if (2'(i) < nsym && i < 3)   w[i].out_byte = (i == 0) ? ch0 : ch1;
          else if (3'(i) < {1'b0, n_data}) w[i].out_byte = chf;
          else                         w[i].out_byte = CH_PAD;
        end
      end
      cnt               = BATCH_CW'(enc_total);
      ns.bit_buffer     = enc_buf;
      ns.bits_held      = enc_rem[3:0];
      ns.chars_mod_four = cmf_after + pads;
    end else if (dgo && dv[6]) begin
      ns.decode_halted = 1'b1;
    end else if (dgo) begin
      ns.bit_buffer = dec_buf;
      if (dec_bits >= 5'd8) begin
        w[0].out_byte     = 8'(dec_buf >> (dec_bits - 5'd8));
        w[0].carries_data = 1'b1;
        cnt               = BATCH_CW'(1);
        ns.bits_held      = 4'(dec_bits - 5'd8);
      end else begin
        ns.bits_held = dec_bits[3:0];
      end
    end

    // End of message: mark the final word, or send a bare end marker.
    if (item.end_of_message) begin
      if (cnt == '0) begin
        cnt                  = BATCH_CW'(1);
        w[0].last_of_message = 1'b1;
      end else begin
        for (int i = 0; i < BATCH_MAX; i++) begin
          if (BATCH_CW'(i + 1) == cnt) w[i].last_of_message = 1'b1;
        end
      end
      ns = '0;
    end

    st_nxt      = ns;
    batch.count = cnt;
    batch.words = w;
  end

endmodule

// ===== src/b64sc_out_buf.sv =====
`include "base64_scrambled_codec_core_macros.svh"

module b64sc_out_buf
  import b64sc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  batch_t              batch,
  output logic                free,
  b64sc_out_if.source         out_ch
);

  result_t [BATCH_MAX-1:0] slots_r, slots_nxt;
  logic [BATCH_CW-1:0]     cnt_r, cnt_nxt;
  logic                    pop;

  always_comb begin
    pop       = cnt_r != '0 && out_ch.ready;
    free      = cnt_r == '0 || (cnt_r == BATCH_CW'(1) && out_ch.ready);
    slots_nxt = slots_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      slots_nxt = batch.words;
      cnt_nxt   = batch.count;
    end else if (pop) begin
      // advance the queue by one word
      for (int i = 0; i < BATCH_MAX - 1; i++) slots_nxt[i] = slots_r[i + 1];
      cnt_nxt = cnt_r - BATCH_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid           = cnt_r != '0;
  assign out_ch.out_byte        = slots_r[0].out_byte;
  assign out_ch.carries_data    = slots_r[0].carries_data;
  assign out_ch.last_of_message = slots_r[0].last_of_message;

  `B64SC_ASSERT_IMP(a_load_when_free, load, free, "batch loaded over pending words")
  `B64SC_ASSERT_NXT(a_stall_holds, out_ch.valid && !out_ch.ready, cnt_r == $past(cnt_r), "fill changed during stall")
  `B64SC_ASSERT_NXT(a_drain_empties, out_ch.ready && cnt_r == BATCH_CW'(1) && !load, cnt_r == '0, "last word not dropped")

endmodule

// ===== src/base64_scrambled_codec_core.sv =====
// Streaming Base64 encoder/decoder with a rotation scramble on the character side. In
// encode mode (direction 0) each raw byte word yields zero, one or two scrambled Base64
// characters, and a word flagged end_of_message also flushes leftover bits and pads with
// '=' to a multiple of four characters; in decode mode (direction 1) each character word
// yields at most one byte, an invalid character (including '=') halts decoding for the
// rest of the message, and trailing partial bits are dropped. An end with nothing to
// send produces one bare word (carries_data 0, last_of_message 1). An input word is
// registered, expanded in one combinational pass into up to four result words, and handed
// to a four-entry output queue that sends one word per cycle while out_ch.ready is high.
// An item produces up to four words at message end; the held word is expanded, and a
// new word accepted, in the cycle the previous batch's last word leaves, so one-word
// items run back to back. The input word is captured in item_r and its result words in
// the output queue registers before the first of them is valid on out_ch.
// Configuration writes are always taken (cfg_ch.ready is tied high) and must only arrive
// while the block is idle; writing direction abandons any partial message, writing a
// shift does not.
module base64_scrambled_codec_core
  import b64sc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  b64sc_in_if.sink     in_ch,
  b64sc_out_if.source  out_ch,
  b64sc_cfg_if.sink    cfg_ch
);

  cfg_t   cfg_r, cfg_nxt;
  state_t state_r, state_nxt, step_state;
  item_t  item_r;
  logic   item_valid_r, item_valid_nxt;
  logic   take, free, cfg_wr, dir_wr;
  batch_t batch;

  // Configuration registers; index decode drops writes beyond the list.
  always_comb begin
    cfg_wr  = cfg_ch.valid && cfg_ch.ready;
    cfg_nxt = cfg_r;
    dir_wr  = 1'b0;
    if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_DIRECTION: begin
          cfg_nxt.direction = cfg_ch.data[0];
          dir_wr            = 1'b1;
        end
        REG_UPPER_SHIFT: cfg_nxt.upper_shift = cfg_ch.data;
        REG_LOWER_SHIFT: cfg_nxt.lower_shift = cfg_ch.data;
        REG_DIGIT_SHIFT: cfg_nxt.digit_shift = cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Process the held word once the output queue can take its batch.
  assign take        = item_valid_r && free;
  assign in_ch.ready = !item_valid_r || take;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      item_valid_nxt = 1'b1;
    end else if (take) begin
      item_valid_nxt = 1'b0;
    end
    // a direction write clears the stream; otherwise advance on each processed word
    if (dir_wr) begin
      state_nxt = '0;
    end else if (take) begin
      state_nxt = step_state;
    end else begin
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.in_byte        <= in_ch.in_byte;
      item_r.has_byte       <= in_ch.has_byte;
      item_r.end_of_message <= in_ch.end_of_message;
    end
    if (!rst_n) begin
      cfg_r        <= CFG_RESET;
      state_r      <= '0;
      item_valid_r <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      state_r      <= state_nxt;
      item_valid_r <= item_valid_nxt;
    end
  end

  b64sc_step u_step (
    .cfg    (cfg_r),
    .st     (state_r),
    .item   (item_r),
    .st_nxt (step_state),
    .batch  (batch)
  );

  b64sc_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (take),
    .batch  (batch),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule
